>>> hdl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg: shared widths, constants and helpers for the escape-time core
// Fixed-point widths derived from the coordinate format, register indexes,
// escape bound and the saturating narrow function.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 28;
  localparam int DIM_BITS   = 12;
  localparam int ITER_BITS  = 16;

  localparam int DIMR_W    = DIM_BITS + 1;              // width/height registers
  localparam int MUL_W     = COORD_BITS + 1;            // shared multiplier operands
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SCALED_W  = COORD_BITS + 1 + DIM_BITS; // (hi - lo) * pixel
  localparam int QUO_W     = SCALED_W + 1;
  localparam int NORM_W    = 2 * COORD_BITS;            // exact squares
  localparam int WIDE_W    = PROD_W + 1;                // pre-saturation sums
  localparam int DIV_CNT_W = $clog2(SCALED_W + 1);
  localparam int CFG_W     = COORD_BITS;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_LEFT   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_RIGHT  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_TOP    = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_BOTTOM = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_MAXIT  = REG_IDX_W'(6);

  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(COORD_MAX);
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = WIDE_W'(COORD_MIN);

  // 4.0 with 2*FRAC_BITS fraction bits
  localparam logic [NORM_W:0] ESC_BOUND = (NORM_W + 1)'(1) << (2 * FRAC_BITS + 2);

  localparam logic signed [COORD_BITS-1:0] RST_LEFT   = -COORD_BITS'(536870912);
  localparam logic signed [COORD_BITS-1:0] RST_RIGHT  = COORD_BITS'(268435456);
  localparam logic signed [COORD_BITS-1:0] RST_TOP    = COORD_BITS'(268435456);
  localparam logic signed [COORD_BITS-1:0] RST_BOTTOM = -COORD_BITS'(268435456);
  localparam logic [DIMR_W-1:0]            RST_WIDTH  = DIMR_W'(900);
  localparam logic [DIMR_W-1:0]            RST_HEIGHT = DIMR_W'(600);
  localparam logic [ITER_BITS-1:0]         RST_MAXIT  = ITER_BITS'(100);

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [WIDE_W-1:0] v
  );
    logic signed [COORD_BITS-1:0] r;
    if (v > WIDE_MAX) begin
      r = COORD_MAX;
    end else if (v < WIDE_MIN) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/mbe_mul.sv
// ----------------------------------------------------------------------------
// mbe_mul: shared signed multiplier
// One registered signed product per cycle; used for the pixel scaling and for
// every square and cross term of the iteration.
// ----------------------------------------------------------------------------
module mbe_mul (
  input  logic                               clk,
  input  logic signed [mbe_pkg::MUL_W-1:0]   a,
  input  logic signed [mbe_pkg::MUL_W-1:0]   b,
  output logic signed [mbe_pkg::PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> hdl/mbe_div.sv
// ----------------------------------------------------------------------------
// mbe_div: signed by unsigned radix-2 divider
// Restoring division on the magnitude, one quotient bit per cycle; quotient
// truncates toward zero. done pulses for one cycle with the quotient valid.
// ----------------------------------------------------------------------------
module mbe_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [mbe_pkg::SCALED_W-1:0]  dividend,
  input  logic        [mbe_pkg::DIMR_W-1:0]    divisor,
  output logic                                 done,
  output logic signed [mbe_pkg::QUO_W-1:0]     quotient
);

  logic                              busy;
  logic [mbe_pkg::DIV_CNT_W-1:0]     cnt;
  logic                              neg;
  logic [mbe_pkg::SCALED_W-1:0]      mag;
  logic [mbe_pkg::DIMR_W-1:0]        rem;
  logic [mbe_pkg::DIMR_W-1:0]        den;
  logic [mbe_pkg::DIMR_W:0]          trial;
  logic                              fits;

  assign trial = {rem, mag[mbe_pkg::SCALED_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          cnt  <= mbe_pkg::DIV_CNT_W'(mbe_pkg::SCALED_W);
        end
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy) begin
      if (start) begin
        neg <= dividend[mbe_pkg::SCALED_W-1];
        mag <= dividend[mbe_pkg::SCALED_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
        rem <= '0;
        den <= divisor;
      end
    end else if (cnt != '0) begin
      rem <= fits ? mbe_pkg::DIMR_W'(trial - {1'b0, den}) : trial[mbe_pkg::DIMR_W-1:0];
      mag <= {mag[mbe_pkg::SCALED_W-2:0], fits};
    end else begin
      quotient <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

>>> hdl/mandelbrot_escape_time_core.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core: Mandelbrot escape count per pixel
// Maps a pixel to c in Q4.28, iterates z = z^2 + c on one shared multiplier
// and returns the number of steps before escape or the iteration limit.
//
//   channel   signals                              direction
//   pixel     in_valid / in_stall, pixel_x/y       in
//   result    out_valid / out_stall, iterations    out
//   config    cfg_write, cfg_index, cfg_data       in
//
// The mapping runs two divisions, one per axis; each iteration step passes
// S_CROSS, S_UPDATE, S_SQ_RE, S_SQ_IM and S_CHECK on the shared multiplier.
// One pixel is in work at a time; in_stall is high until the result is parked
// in the output register, which holds one word while the next pixel runs.
// Reset (sync, active high) restores the default view and limit.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mbe_pkg::DIM_BITS-1:0]         pixel_x,
  input  logic [mbe_pkg::DIM_BITS-1:0]         pixel_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mbe_pkg::ITER_BITS-1:0]        iterations,
  input  logic                                 cfg_write,
  input  logic [mbe_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [mbe_pkg::CFG_W-1:0]            cfg_data
);

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_MAPX_MUL  = 14'b00000000000010,
    S_MAPX_DIV  = 14'b00000000000100,
    S_MAPX_WAIT = 14'b00000000001000,
    S_MAPY_MUL  = 14'b00000000010000,
    S_MAPY_DIV  = 14'b00000000100000,
    S_MAPY_WAIT = 14'b00000001000000,
    S_NEG_IM    = 14'b00000010000000,
    S_CROSS     = 14'b00000100000000,
    S_UPDATE    = 14'b00001000000000,
    S_SQ_RE     = 14'b00010000000000,
    S_SQ_IM     = 14'b00100000000000,
    S_CHECK     = 14'b01000000000000,
    S_FINISH    = 14'b10000000000000
  } state_t;

  state_t state;

  // configuration
  logic signed [mbe_pkg::COORD_BITS-1:0] left_edge, right_edge, top_edge, bottom_edge;
  logic [mbe_pkg::DIMR_W-1:0]            image_width, image_height;
  logic [mbe_pkg::ITER_BITS-1:0]         max_iter;

  // working registers
  logic [mbe_pkg::DIM_BITS-1:0]          px, py;
  logic signed [mbe_pkg::COORD_BITS-1:0] cr, ci, zr, zi, nr, ni;
  logic [mbe_pkg::NORM_W-1:0]            sq_r, sq_i, sqr_n;
  logic signed [mbe_pkg::NORM_W:0]       dsq;
  logic [mbe_pkg::ITER_BITS-1:0]         count;

  // shared units
  logic signed [mbe_pkg::MUL_W-1:0]      mul_a, mul_b;
  logic signed [mbe_pkg::PROD_W-1:0]     prod;
  logic                                  div_start, div_done;
  logic [mbe_pkg::DIMR_W-1:0]            div_den, dim_sel;
  logic signed [mbe_pkg::QUO_W-1:0]      div_q;

  logic signed [mbe_pkg::WIDE_W-1:0]     nr_wide, ni_wide, map_lo_sum;
  logic [mbe_pkg::NORM_W:0]              norm;
  logic                                  escape, out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MAPX_MUL: begin
        mul_a = mbe_pkg::MUL_W'(right_edge) - mbe_pkg::MUL_W'(left_edge);
        mul_b = $signed(mbe_pkg::MUL_W'(px));
      end
      S_MAPY_MUL: begin
        mul_a = mbe_pkg::MUL_W'(top_edge) - mbe_pkg::MUL_W'(bottom_edge);
        mul_b = $signed(mbe_pkg::MUL_W'(py));
      end
      S_CROSS: begin
        mul_a = mbe_pkg::MUL_W'(zr);
        mul_b = mbe_pkg::MUL_W'(zi);
      end
      S_SQ_RE: begin
        mul_a = mbe_pkg::MUL_W'(nr);
        mul_b = mbe_pkg::MUL_W'(nr);
      end
      S_SQ_IM: begin
        mul_a = mbe_pkg::MUL_W'(ni);
        mul_b = mbe_pkg::MUL_W'(ni);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mbe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // a zero dimension divides by one
  assign dim_sel   = (state == S_MAPY_DIV) ? image_height : image_width;
  assign div_den   = (dim_sel == '0) ? mbe_pkg::DIMR_W'(1) : dim_sel;
  assign div_start = (state == S_MAPX_DIV) || (state == S_MAPY_DIV);

  mbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[mbe_pkg::SCALED_W-1:0]),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign map_lo_sum = mbe_pkg::WIDE_W'((state == S_MAPY_WAIT) ? bottom_edge : left_edge)
                    + mbe_pkg::WIDE_W'(div_q);

  // >>> floors, matching the arithmetic shift of the fixed-point format
  assign nr_wide = mbe_pkg::WIDE_W'(dsq >>> mbe_pkg::FRAC_BITS) + mbe_pkg::WIDE_W'(cr);
  assign ni_wide = mbe_pkg::WIDE_W'(prod >>> (mbe_pkg::FRAC_BITS - 1))
                 + mbe_pkg::WIDE_W'(ci);

  assign norm   = {1'b0, sqr_n} + {1'b0, prod[mbe_pkg::NORM_W-1:0]};
  assign escape = (norm >= mbe_pkg::ESC_BOUND) || (count >= max_iter);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge    <= mbe_pkg::RST_LEFT;
      right_edge   <= mbe_pkg::RST_RIGHT;
      top_edge     <= mbe_pkg::RST_TOP;
      bottom_edge  <= mbe_pkg::RST_BOTTOM;
      image_width  <= mbe_pkg::RST_WIDTH;
      image_height <= mbe_pkg::RST_HEIGHT;
      max_iter     <= mbe_pkg::RST_MAXIT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mbe_pkg::REG_LEFT:   left_edge    <= cfg_data[mbe_pkg::COORD_BITS-1:0];
        mbe_pkg::REG_RIGHT:  right_edge   <= cfg_data[mbe_pkg::COORD_BITS-1:0];
        mbe_pkg::REG_TOP:    top_edge     <= cfg_data[mbe_pkg::COORD_BITS-1:0];
        mbe_pkg::REG_BOTTOM: bottom_edge  <= cfg_data[mbe_pkg::COORD_BITS-1:0];
        mbe_pkg::REG_WIDTH:  image_width  <= cfg_data[mbe_pkg::DIMR_W-1:0];
        mbe_pkg::REG_HEIGHT: image_height <= cfg_data[mbe_pkg::DIMR_W-1:0];
        mbe_pkg::REG_MAXIT:  max_iter     <= cfg_data[mbe_pkg::ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      // in S_FINISH the output register is reloaded below
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:      if (in_valid) state <= S_MAPX_MUL;
        S_MAPX_MUL:  state <= S_MAPX_DIV;
        S_MAPX_DIV:  state <= S_MAPX_WAIT;
        S_MAPX_WAIT: if (div_done) state <= S_MAPY_MUL;
        S_MAPY_MUL:  state <= S_MAPY_DIV;
        S_MAPY_DIV:  state <= S_MAPY_WAIT;
        S_MAPY_WAIT: if (div_done) state <= S_NEG_IM;
        S_NEG_IM: begin
          count <= '0;
          state <= S_CROSS;
        end
        S_CROSS:     state <= S_UPDATE;
        S_UPDATE:    state <= S_SQ_RE;
        S_SQ_RE:     state <= S_SQ_IM;
        S_SQ_IM:     state <= S_CHECK;
        S_CHECK: begin
          if (escape) begin
            state <= S_FINISH;
          end else begin
            count <= count + 1'b1;
            state <= S_CROSS;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          px <= pixel_x;
          py <= pixel_y;
        end
      end
      S_MAPX_WAIT: if (div_done) cr <= mbe_pkg::sat_coord(map_lo_sum);
      S_MAPY_WAIT: if (div_done) ci <= mbe_pkg::sat_coord(map_lo_sum);
      S_NEG_IM: begin
        // imaginary axis is flipped; only the most negative value needs a clamp
        ci   <= (ci == mbe_pkg::COORD_MIN) ? mbe_pkg::COORD_MAX : -ci;
        zr   <= '0;
        zi   <= '0;
        sq_r <= '0;
        sq_i <= '0;
      end
      S_CROSS:  dsq <= $signed({1'b0, sq_r}) - $signed({1'b0, sq_i});
      S_UPDATE: begin
        nr <= mbe_pkg::sat_coord(nr_wide);
        ni <= mbe_pkg::sat_coord(ni_wide);
      end
      S_SQ_IM:  sqr_n <= prod[mbe_pkg::NORM_W-1:0];
      S_CHECK: begin
        // squares of z' are the squares of the next z
        if (!escape) begin
          zr   <= nr;
          zi   <= ni;
          sq_r <= sqr_n;
          sq_i <= prod[mbe_pkg::NORM_W-1:0];
        end
      end
      S_FINISH: if (out_free) iterations <= count;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_MAPX_MUL))
    else $error("accepted word did not start mapping");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_MAPX_WAIT || state == S_MAPY_WAIT))
    else $error("divider finished outside a wait state");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && !escape) |=> (count == $past(count) + 1'b1) && (state == S_CROSS))
    else $error("iteration count did not advance");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> out_valid && (iterations == $past(count)))
    else $error("result word not loaded");
`endif

endmodule
